// ===== hdl/hsre_pkg.sv =====
// ----------------------------------------------------------------------------
// hsre_pkg: shared types and constants of the hearable-set row expander
// Matrix geometry, stream field widths, the function code and the structs
// that pass between the sequencer and the top level.
// ----------------------------------------------------------------------------
package hsre_pkg;

    localparam int MAX_CLUSTERS  = 256;
    localparam int WORDS_PER_ROW = 8;
    localparam int WORD_W        = 32;
    localparam int ROW_BITS      = WORD_W * WORDS_PER_ROW;
    localparam int ROW_IDX_W     = $clog2(MAX_CLUSTERS);
    localparam int WIDX_W        = $clog2(WORDS_PER_ROW);
    localparam int CNT_W         = $clog2(MAX_CLUSTERS) + 1;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int S_ROW_LSB  = 0;
    localparam int S_WIDX_LSB = S_ROW_LSB + ROW_IDX_W;
    localparam int S_BITS_LSB = S_WIDX_LSB + WIDX_W;
    localparam int M_WIDX_LSB = 0;
    localparam int M_BITS_LSB = M_WIDX_LSB + WIDX_W;
    localparam int M_CNT_LSB  = M_BITS_LSB + WORD_W;
    localparam int M_BAD_LSB  = M_CNT_LSB + CNT_W;
    localparam int M_USED_W   = M_BAD_LSB + 1;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [CNT_W-1:0] CLUSTER_COUNT_RESET = CNT_W'(MAX_CLUSTERS);

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [ROW_IDX_W-1:0] row_idx_t;
    typedef logic [WIDX_W-1:0]    widx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ROW_BITS-1:0]  row_t;

    typedef enum logic {
        REG_CLUSTER_COUNT = 1'b0,
        REG_UNUSED        = 1'b1
    } reg_idx_t;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_EXPAND = 1'b1
    } func_t;

    typedef struct packed {
        logic     we;
        row_idx_t wrow;
        widx_t    wword;
        word_t    wdata;
        logic     re;
        row_idx_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic  valid;
        widx_t widx;
        word_t bits;
        cnt_t  count;
        logic  bad;
        logic  last;
    } emit_t;

endpackage

// ===== hdl/hearable_set_row_expand.sv =====
// ----------------------------------------------------------------------------
// hearable_set_row_expand: top level of the hearable-set row expander
// Loads a bit matrix word by word and expands one row into the OR of that row and all
// rows it selects, sent as eight words with the set-bit count on the last.
// ----------------------------------------------------------------------------
// Load transfer: written straight into its bank; the block stays ready for the next input.
// Expand transfer: row fetch, a 256-step scan of the bank read port, one row
//   per step, a drain step and an 8-step bit count, then one result word a
//   cycle while the output side does not stall; no new input is taken until
//   the last result word has been handed to the output register.
// Reset: sequencer idle, output empty, cluster count 256; matrix not cleared.
module hearable_set_row_expand (
    input  logic                          aclk,
    input  logic                          aresetn,

    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: row_index[7:0], word_index[10:8], word_bits[42:11], zero fill
    input  logic [hsre_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: func[0]
    input  logic                          s_tuser,

    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: out_word_index[2:0], out_bits[34:3], set_count[43:35],
    //        bad_bit[44], zero fill
    output logic [hsre_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsre_pkg::PADDR_W-1:0]  paddr,
    input  logic [hsre_pkg::PDATA_W-1:0]  pwdata,
    output logic [hsre_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import hsre_pkg::*;

    cnt_t     cluster_count_reg;
    cnt_t     lim;
    reg_idx_t reg_idx;
    logic     cfg_write;

    mem_req_t mem_req;
    row_t     rd_row;
    emit_t    emit;
    logic     emit_take;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // ---- configuration: one register, every access completes at once ----
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_count_reg <= CLUSTER_COUNT_RESET;
        end else if (cfg_write && (reg_idx == REG_CLUSTER_COUNT)) begin
            cluster_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLUSTER_COUNT: prdata = PDATA_W'(cluster_count_reg);
            default:           prdata = '0;
        endcase
    end

    // clamp the cluster count to the matrix size
    assign lim = (cluster_count_reg > cnt_t'(MAX_CLUSTERS)) ? cnt_t'(MAX_CLUSTERS)
                                                            : cluster_count_reg;

    // ---- sequencer ----
    hsre_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tuser)),
        .in_row    (s_tdata[S_ROW_LSB +: ROW_IDX_W]),
        .in_widx   (s_tdata[S_WIDX_LSB +: WIDX_W]),
        .in_bits   (s_tdata[S_BITS_LSB +: WORD_W]),
        .lim       (lim),
        .mem_req   (mem_req),
        .rd_row    (rd_row),
        .emit      (emit),
        .emit_take (emit_take)
    );

    // ---- matrix: one bank per word column, all read at the same row ----
    for (genvar b = 0; b < WORDS_PER_ROW; b++) begin : g_bank
        hsre_bank u_bank (
            .aclk  (aclk),
            .we    (mem_req.we && (mem_req.wword == widx_t'(b))),
            .waddr (mem_req.wrow),
            .wdata (mem_req.wdata),
            .re    (mem_req.re),
            .raddr (mem_req.raddr),
            .rdata (rd_row[WORD_W*b +: WORD_W])
        );
    end

    // ---- output register: load a word whenever the slot is free or draining ----
    assign emit_take = emit.valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_take) begin
            m_tdata_reg <= M_TDATA_W'({emit.bad, emit.count, emit.bits, emit.widx});
            m_tlast_reg <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hdl/hsre_bank.sv =====
// ----------------------------------------------------------------------------
// hsre_bank: one word column of the visibility matrix
// Holds word w of every row; one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module hsre_bank (
    input  logic              aclk,
    input  logic              we,
    input  hsre_pkg::row_idx_t waddr,
    input  hsre_pkg::word_t   wdata,
    input  logic              re,
    input  hsre_pkg::row_idx_t raddr,
    output hsre_pkg::word_t   rdata
);
    import hsre_pkg::*;

    word_t mem [MAX_CLUSTERS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/hsre_core.sv =====
// ----------------------------------------------------------------------------
// hsre_core: sequencer of the row expander
// Takes input transfers, drives the matrix banks, ORs the selected rows into
// the accumulator one row a cycle, counts the bits and hands out the words.
// ----------------------------------------------------------------------------
module hsre_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsre_pkg::func_t    in_func,
    input  hsre_pkg::row_idx_t in_row,
    input  hsre_pkg::widx_t    in_widx,
    input  hsre_pkg::word_t    in_bits,
    input  hsre_pkg::cnt_t     lim,
    output hsre_pkg::mem_req_t mem_req,
    input  hsre_pkg::row_t     rd_row,
    output hsre_pkg::emit_t    emit,
    input  logic               emit_take
);
    import hsre_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SRC   = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_COUNT = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t   state_reg, state_next;
    row_idx_t c_reg, c_next;
    logic     pend_reg, pend_next;
    logic     bad_reg, bad_next;
    row_t     src_reg, src_next;
    word_t    acc_reg [WORDS_PER_ROW];
    word_t    acc_next [WORDS_PER_ROW];
    cnt_t     cnt_reg, cnt_next;
    widx_t    wcnt_reg, wcnt_next;

    logic accept;
    logic in_lim;
    logic [5:0] word_pop;

    function automatic word_t below_mask(widx_t w, cnt_t l);
        cnt_t base;
        cnt_t d;
        base = cnt_t'({w, 5'b0});
        d    = l - base;
        if (l <= base) begin
            return '0;
        end else if (d >= cnt_t'(WORD_W)) begin
            return '1;
        end else begin
            return (word_t'(1) << d[4:0]) - word_t'(1);
        end
    endfunction

    function automatic logic [5:0] pop32(word_t v);
        logic [2:0] nib [8];
        logic [5:0] sum;
        for (int i = 0; i < 8; i++) begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + 6'(nib[i]);
        end
        return sum;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_lim   = ({1'b0, c_reg} < lim);
    assign word_pop = pop32(acc_reg[0] & below_mask(wcnt_reg, lim));

    always_comb begin
        mem_req.we    = accept && (in_func == FUNC_LOAD);
        mem_req.wrow  = in_row;
        mem_req.wword = in_widx;
        mem_req.wdata = in_bits;
        mem_req.re    = (accept && (in_func == FUNC_EXPAND)) || (state_reg == ST_SCAN);
        mem_req.raddr = (state_reg == ST_SCAN) ? c_reg : in_row;
    end

    always_comb begin
        emit.valid = (state_reg == ST_EMIT);
        emit.widx  = wcnt_reg;
        emit.bits  = acc_reg[0];
        emit.last  = (wcnt_reg == widx_t'(WORDS_PER_ROW - 1));
        emit.count = emit.last ? cnt_reg : '0;
        emit.bad   = bad_reg;
    end

    always_comb begin
        state_next = state_reg;
        c_next     = c_reg;
        pend_next  = pend_reg;
        bad_next   = bad_reg;
        src_next   = src_reg;
        cnt_next   = cnt_reg;
        wcnt_next  = wcnt_reg;
        for (int i = 0; i < WORDS_PER_ROW; i++) begin
            acc_next[i] = acc_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_func == FUNC_EXPAND)) begin
                    state_next = ST_SRC;
                end
            end
            ST_SRC: begin
                // capture the named row as both seed and selector
                src_next = rd_row;
                for (int i = 0; i < WORDS_PER_ROW; i++) begin
                    acc_next[i] = rd_row[WORD_W*i +: WORD_W];
                end
                c_next     = '0;
                pend_next  = 1'b0;
                bad_next   = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN, ST_DRAIN: begin
                if (pend_reg) begin
                    for (int i = 0; i < WORDS_PER_ROW; i++) begin
                        acc_next[i] = acc_reg[i] | rd_row[WORD_W*i +: WORD_W];
                    end
                end
                if (state_reg == ST_SCAN) begin
                    pend_next = src_reg[0] && in_lim;
                    bad_next  = bad_reg || (src_reg[0] && !in_lim);
                    src_next  = src_reg >> 1;
                    c_next    = c_reg + row_idx_t'(1);
                    if (c_reg == row_idx_t'(MAX_CLUSTERS - 1)) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                    wcnt_next  = '0;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                cnt_next = cnt_reg + cnt_t'(word_pop);
                for (int i = 0; i < WORDS_PER_ROW; i++) begin
                    acc_next[i] = acc_reg[(i + 1) % WORDS_PER_ROW];
                end
                wcnt_next = wcnt_reg + widx_t'(1);
                if (wcnt_reg == widx_t'(WORDS_PER_ROW - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_take) begin
                    for (int i = 0; i < WORDS_PER_ROW; i++) begin
                        acc_next[i] = acc_reg[(i + 1) % WORDS_PER_ROW];
                    end
                    wcnt_next = wcnt_reg + widx_t'(1);
                    if (emit.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            c_reg     <= '0;
            pend_reg  <= 1'b0;
            wcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            c_reg     <= c_next;
            pend_reg  <= pend_next;
            wcnt_reg  <= wcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bad_reg <= bad_next;
        src_reg <= src_next;
        cnt_reg <= cnt_next;
        for (int i = 0; i < WORDS_PER_ROW; i++) begin
            acc_reg[i] <= acc_next[i];
        end
    end

endmodule
